[rtl/sample_stats_distinct_assert.svh]
// Assertion macros used by the checker file sstat_checker.sv.
`ifndef SAMPLE_STATS_DISTINCT_ASSERT_SVH
`define SAMPLE_STATS_DISTINCT_ASSERT_SVH

// Consequent checked in the cycle after the antecedent.
`define SSD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sample_stats_distinct: next-cycle check failed");

// Consequent checked in the same cycle as the antecedent.
`define SSD_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sample_stats_distinct: same-cycle check failed");

`endif

[rtl/sstat_pkg.sv]
`timescale 1ns / 1ps

package sstat_pkg;

   localparam int SAMPLE_BITS_DEF = 16;

   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_ADD   = 1'b1;

   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 1;

   localparam int VALUE_W = 16;
   localparam int COUNT_W = 32;
   localparam int SUM_W   = 48;
   localparam int DIST_W  = 17;

   localparam int RSP_CNT_LSB  = 0;
   localparam int RSP_MIN_LSB  = RSP_CNT_LSB + COUNT_W;
   localparam int RSP_MAX_LSB  = RSP_MIN_LSB + VALUE_W;
   localparam int RSP_SUM_LSB  = RSP_MAX_LSB + VALUE_W;
   localparam int RSP_MAG_LSB  = RSP_SUM_LSB + SUM_W;
   localparam int RSP_ZERO_LSB = RSP_MAG_LSB + SUM_W;
   localparam int RSP_DIST_LSB = RSP_ZERO_LSB + COUNT_W;
   localparam int RSP_USED_W   = RSP_DIST_LSB + DIST_W;
   localparam int RSP_DATA_W   = ((RSP_USED_W + 7) / 8) * 8;

   typedef struct packed {
      logic [COUNT_W-1:0]        sample_count;
      logic signed [VALUE_W-1:0] minimum;
      logic signed [VALUE_W-1:0] maximum;
      logic signed [SUM_W-1:0]   total;
      logic [SUM_W-1:0]          total_magnitude;
      logic [COUNT_W-1:0]        zero_count;
      logic [DIST_W-1:0]         distinct_count;
   } stats_type;

   typedef struct packed {
      logic upd;
      logic clr;
      logic fresh;
   } acc_ctrl_type;

   function automatic logic [RSP_DATA_W-1:0] pack_stats(input stats_type s);
      logic [RSP_DATA_W-1:0] d;
      d = '0;
      d[RSP_CNT_LSB  +: COUNT_W] = s.sample_count;
      d[RSP_MIN_LSB  +: VALUE_W] = s.minimum;
      d[RSP_MAX_LSB  +: VALUE_W] = s.maximum;
      d[RSP_SUM_LSB  +: SUM_W]   = s.total;
      d[RSP_MAG_LSB  +: SUM_W]   = s.total_magnitude;
      d[RSP_ZERO_LSB +: COUNT_W] = s.zero_count;
      d[RSP_DIST_LSB +: DIST_W]  = s.distinct_count;
      return d;
   endfunction

endpackage

[rtl/sample_stats_distinct.sv]
`timescale 1ns / 1ps

// Channel   Direction  Group               Contents
// request   in         req_tvalid/tready   tuser: opcode; tdata: sample
// response  out        rsp_tvalid/tready   tdata: the seven statistics
//
// One request is taken per cycle while responses drain; each response passes
// through the registered map read (stage s1) and then the response register.
// Reset and every clear request start a sweep through all 2**(SAMPLE_BITS-3) bytes
// (8192 at the default width) of the presence map; req_tready is low then.
// A stalled response holds the pipeline, but an empty stage s1 still lets
// one request in.
module sample_stats_distinct #(
   parameter int SAMPLE_BITS = sstat_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sstat_pkg::REQ_USER_W-1:0]  req_tuser,  // [0] opcode
   input  logic [sstat_pkg::REQ_DATA_W-1:0]  req_tdata,  // [15:0] sample
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // sample_count, minimum, maximum, total, total_magnitude, zero_count,
   // distinct_count, zero fill.
   output logic [sstat_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import sstat_pkg::*;

   localparam int ADDR_W = SAMPLE_BITS - 3;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_op_ff;
   logic [SAMPLE_BITS-1:0] s1_code_ff;
   logic                   fwd_ff, fwd_in;
   logic [7:0]             fwd_byte_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;

   logic                   adv;
   logic                   s1_go;
   logic                   accept;
   logic                   map_busy;
   logic [7:0]             rd_byte;
   logic [7:0]             cur_byte;
   logic [7:0]             bit_mask;
   logic [7:0]             new_byte;
   logic [ADDR_W-1:0]      req_addr;
   acc_ctrl_type           acc_ctrl;
   stats_type              stats_next;

   assign adv      = !rsp_valid_ff || rsp_tready;
   assign s1_go    = s1_valid_ff && adv;
   assign req_addr = req_tdata[SAMPLE_BITS-1:3];

   assign req_tready = !map_busy && !(s1_valid_ff && s1_op_ff == OP_CLEAR)
                       && (!s1_valid_ff || adv);
   assign accept     = req_tvalid && req_tready;

   assign cur_byte = fwd_ff ? fwd_byte_ff : rd_byte;
   assign bit_mask = 8'(1) << s1_code_ff[2:0];
   assign new_byte = cur_byte | bit_mask;

   always_comb begin
      acc_ctrl.upd   = s1_go && s1_op_ff == OP_ADD;
      acc_ctrl.clr   = s1_go && s1_op_ff == OP_CLEAR;
      acc_ctrl.fresh = (cur_byte & bit_mask) == 8'h00;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      fwd_in = s1_valid_ff && s1_op_ff == OP_ADD
               && s1_code_ff[SAMPLE_BITS-1:3] == req_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_tuser[0];
         s1_code_ff  <= req_tdata[SAMPLE_BITS-1:0];
         fwd_ff      <= fwd_in;
         fwd_byte_ff <= new_byte;
      end
      if (s1_go) begin
         rsp_data_ff <= pack_stats(stats_next);
      end
   end

   sstat_map #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_map (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (accept),
      .rd_addr     (req_addr),
      .rd_data     (rd_byte),
      .wr_en       (acc_ctrl.upd),
      .wr_addr     (s1_code_ff[SAMPLE_BITS-1:3]),
      .wr_data     (new_byte),
      .clear_start (acc_ctrl.clr),
      .busy        (map_busy)
   );

   sstat_acc #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_acc (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (acc_ctrl),
      .sample     ($signed(s1_code_ff)),
      .stats_next (stats_next)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/sstat_map.sv]
`timescale 1ns / 1ps

module sstat_map #(
   parameter int SAMPLE_BITS = sstat_pkg::SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [SAMPLE_BITS-4:0] rd_addr,
   output logic [7:0]             rd_data,
   input  logic                   wr_en,
   input  logic [SAMPLE_BITS-4:0] wr_addr,
   input  logic [7:0]             wr_data,
   input  logic                   clear_start,
   output logic                   busy
);
   import sstat_pkg::*;

   localparam int ADDR_W = SAMPLE_BITS - 3;
   localparam int DEPTH  = 2 ** ADDR_W;

   logic [7:0]        mem [DEPTH];
   logic [7:0]        rd_data_ff;
   logic              busy_ff, busy_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              we;
   logic [ADDR_W-1:0] waddr;
   logic [7:0]        wdata;

   always_comb begin
      busy_in  = busy_ff;
      sweep_in = sweep_ff;
      if (busy_ff) begin
         sweep_in = sweep_ff + 1'b1;
         if (sweep_ff == {ADDR_W{1'b1}}) begin
            busy_in = 1'b0;
         end
      end else if (clear_start) begin
         busy_in  = 1'b1;
         sweep_in = '0;
      end
   end

   always_comb begin
      we    = busy_ff || wr_en;
      waddr = busy_ff ? sweep_ff : wr_addr;
      wdata = busy_ff ? 8'h00 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         sweep_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

[rtl/sstat_acc.sv]
`timescale 1ns / 1ps

module sstat_acc #(
   parameter int SAMPLE_BITS = sstat_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sstat_pkg::acc_ctrl_type       ctrl,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output sstat_pkg::stats_type          stats_next
);
   import sstat_pkg::*;

   localparam logic signed [SAMPLE_BITS-1:0] MIN_INIT = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] MAX_INIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [SUM_W-1:0]              mag_ff, mag_in;
   logic [COUNT_W-1:0]            cnt_ff, cnt_in;
   logic [COUNT_W-1:0]            zero_ff, zero_in;
   logic [DIST_W-1:0]             dist_ff, dist_in;
   logic [SAMPLE_BITS-1:0]        mag;

   assign mag = sample[SAMPLE_BITS-1] ? ($unsigned(~sample) + 1'b1) : $unsigned(sample);

   always_comb begin
      min_in  = min_ff;
      max_in  = max_ff;
      sum_in  = sum_ff;
      mag_in  = mag_ff;
      cnt_in  = cnt_ff;
      zero_in = zero_ff;
      dist_in = dist_ff;
      if (ctrl.clr) begin
         min_in  = MIN_INIT;
         max_in  = MAX_INIT;
         sum_in  = '0;
         mag_in  = '0;
         cnt_in  = '0;
         zero_in = '0;
         dist_in = '0;
      end else if (ctrl.upd) begin
         if (sample < min_ff) begin
            min_in = sample;
         end
         if (sample > max_ff) begin
            max_in = sample;
         end
         sum_in = sum_ff + $unsigned(SUM_W'(sample));
         mag_in = mag_ff + SUM_W'(mag);
         cnt_in = cnt_ff + 1'b1;
         if (sample == '0) begin
            zero_in = zero_ff + 1'b1;
         end
         if (ctrl.fresh) begin
            dist_in = dist_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= MIN_INIT;
         max_ff  <= MAX_INIT;
         sum_ff  <= '0;
         mag_ff  <= '0;
         cnt_ff  <= '0;
         zero_ff <= '0;
         dist_ff <= '0;
      end else begin
         min_ff  <= min_in;
         max_ff  <= max_in;
         sum_ff  <= sum_in;
         mag_ff  <= mag_in;
         cnt_ff  <= cnt_in;
         zero_ff <= zero_in;
         dist_ff <= dist_in;
      end
   end

   always_comb begin
      stats_next.sample_count    = cnt_in;
      stats_next.minimum         = VALUE_W'(min_in);
      stats_next.maximum         = VALUE_W'(max_in);
      stats_next.total           = sum_in;
      stats_next.total_magnitude = mag_in;
      stats_next.zero_count      = zero_in;
      stats_next.distinct_count  = dist_in;
   end

endmodule

[rtl/sstat_checker.sv]
`timescale 1ns / 1ps
`include "sample_stats_distinct_assert.svh"

module sstat_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [sstat_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [sstat_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sstat_pkg::*;

   logic empty_stats;
   logic inverted;
   logic rsp_stall;
   logic clear_taken;

   assign inverted = $signed(rsp_tdata[RSP_MAX_LSB +: VALUE_W])
                     < $signed(rsp_tdata[RSP_MIN_LSB +: VALUE_W]);
   assign empty_stats = rsp_tdata[RSP_CNT_LSB +: COUNT_W] == '0
                        && rsp_tdata[RSP_SUM_LSB +: SUM_W] == '0
                        && rsp_tdata[RSP_MAG_LSB +: SUM_W] == '0
                        && rsp_tdata[RSP_ZERO_LSB +: COUNT_W] == '0
                        && rsp_tdata[RSP_DIST_LSB +: DIST_W] == '0;
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign clear_taken = req_tvalid && req_tready && req_tuser[0] == OP_CLEAR;

   `SSD_ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   `SSD_ASSERT_NEXT(reset_sweep_a, clock, 1'b0, reset, !req_tready)
   `SSD_ASSERT_NEXT(clear_blocks_a, clock, reset, clear_taken, !req_tready)
   `SSD_ASSERT_SAME(empty_stats_a, clock, reset, rsp_tvalid && inverted, empty_stats)

endmodule

bind sample_stats_distinct sstat_checker u_sstat_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/sample_stats_distinct_test.sv]
`timescale 1ns / 1ps

module sample_stats_distinct_test;

   import sstat_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAP_SIZE    = 1 << SAMPLE_BITS_DEF;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count   = 0;
   int error_count   = 0;
   int request_count = 0;
   int clear_count   = 0;
   int checked_count = 0;

   stats_type model_stats;
   logic      seen_value [MAP_SIZE];
   stats_type pending_stats [$];

   sample_stats_distinct u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic clear_model();
      model_stats.sample_count    = '0;
      model_stats.minimum         = 16'h7FFF;
      model_stats.maximum         = 16'h8000;
      model_stats.total           = '0;
      model_stats.total_magnitude = '0;
      model_stats.zero_count      = '0;
      model_stats.distinct_count  = '0;
      foreach (seen_value[i]) seen_value[i] = 1'b0;
   endtask

   task automatic predict_stats(input logic opcode, input logic [15:0] raw);
      logic [16:0] magnitude;
      if (opcode == OP_CLEAR) begin
         clear_model();
      end else begin
         magnitude = raw[15] ? 17'(17'h10000 - {1'b0, raw}) : {1'b0, raw};
         if ($signed(raw) < $signed(model_stats.minimum)) model_stats.minimum = raw;
         if ($signed(raw) > $signed(model_stats.maximum)) model_stats.maximum = raw;
         model_stats.total = model_stats.total + {{32{raw[15]}}, raw};
         model_stats.total_magnitude = model_stats.total_magnitude + 48'(magnitude);
         if (raw == 16'h0000) model_stats.zero_count = model_stats.zero_count + 1;
         if (!seen_value[raw]) begin
            seen_value[raw] = 1'b1;
            model_stats.distinct_count = model_stats.distinct_count + 1'b1;
         end
         model_stats.sample_count = model_stats.sample_count + 1;
      end
      pending_stats.push_back(model_stats);
   endtask

   task automatic send_request(input logic opcode, input logic [15:0] raw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tuser[0] <= opcode;
      req_tdata    <= raw;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_stats(opcode, raw);
      request_count++;
      if (opcode == OP_CLEAR) clear_count++;
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_val,
                              input logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      stats_type exp_stats;
      stats_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.sample_count    = rsp_tdata[RSP_CNT_LSB  +: COUNT_W];
         got.minimum         = rsp_tdata[RSP_MIN_LSB  +: VALUE_W];
         got.maximum         = rsp_tdata[RSP_MAX_LSB  +: VALUE_W];
         got.total           = rsp_tdata[RSP_SUM_LSB  +: SUM_W];
         got.total_magnitude = rsp_tdata[RSP_MAG_LSB  +: SUM_W];
         got.zero_count      = rsp_tdata[RSP_ZERO_LSB +: COUNT_W];
         got.distinct_count  = rsp_tdata[RSP_DIST_LSB +: DIST_W];
         if (pending_stats.size() == 0) begin
            $error("Response arrived with no request outstanding");
            error_count++;
         end else begin
            exp_stats = pending_stats.pop_front();
            checked_count++;
            check_field("sample_count", exp_stats.sample_count, got.sample_count);
            check_field("minimum", exp_stats.minimum, got.minimum);
            check_field("maximum", exp_stats.maximum, got.maximum);
            check_field("total", exp_stats.total, got.total);
            check_field("total_magnitude", exp_stats.total_magnitude,
                        got.total_magnitude);
            check_field("zero_count", exp_stats.zero_count, got.zero_count);
            check_field("distinct_count", exp_stats.distinct_count,
                        got.distinct_count);
         end
      end
   end

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3, 4:    return 16'($urandom_range(16)) - 16'd8;
         5:       return 16'($urandom_range(255)) - 16'd128;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      send_request(OP_ADD,   16'h7FFF);
      send_request(OP_ADD,   16'h8000);
      send_request(OP_ADD,   16'h0000);
      send_request(OP_ADD,   16'h0001);
      send_request(OP_ADD,   16'hFFFF);
      send_request(OP_ADD,   16'h0000);
      send_request(OP_ADD,   16'h7FFF);
      send_request(OP_ADD,   16'h5555);
      send_request(OP_ADD,   16'hAAAA);
      send_request(OP_CLEAR, 16'h0000);
      send_request(OP_ADD,   16'h8000);
      send_request(OP_ADD,   16'h8000);
      send_request(OP_ADD,   16'h0000);
      send_request(OP_CLEAR, 16'hFFFF);
      send_request(OP_CLEAR, 16'h1234);
      send_request(OP_ADD,   16'h0064);
      send_request(OP_ADD,   16'hFF9C);
      send_request(OP_ADD,   16'h7FFE);
      send_request(OP_ADD,   16'h8001);
   endtask

   task automatic test_random(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(119) == 0) send_request(OP_CLEAR, 16'($urandom));
         else                          send_request(OP_ADD, pick_sample());
         if (i == count / 2) wait_for_responses();
      end
   endtask

   // Neighboring values that share map bytes, first rising and then falling.
   task automatic test_dense_values();
      logic [15:0] base;
      base          = 16'($urandom) & 16'hFFF8;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_request(OP_CLEAR, 16'h0000);
      for (int i = 0; i < 64; i++) send_request(OP_ADD, base + 16'(i));
      for (int i = 63; i >= 0; i--) send_request(OP_ADD, base + 16'(i));
      for (int i = 0; i < 8; i++) send_request(OP_ADD, pick_sample());
      send_request(OP_CLEAR, 16'h0000);
      send_request(OP_ADD, pick_sample());
   endtask

   initial begin
      clear_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 26;
      recv_idle_pct = 52;
      test_directed();
      test_random(580, 26, 52);
      test_random(580, 52, 26);
      test_random(580, 0, 0);
      test_dense_values();
      wait_for_responses();
      repeat (20) @(posedge clock);
      $display("Sent %0d requests (%0d clears) and checked %0d responses,",
               request_count, clear_count, checked_count);
      $display("including back-to-back runs of neighboring values in the map.");
      if (error_count == 0 && pending_stats.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/sstat_pkg.sv
rtl/sstat_map.sv
rtl/sstat_acc.sv
rtl/sample_stats_distinct.sv
rtl/sstat_checker.sv
tb/sample_stats_distinct_test.sv
